// ===== rtl/itbs_pkg.sv =====
// ----------------------------------------------------------------------------
// itbs_pkg
// Shared constants, codes and types of the interval table search block.
// ----------------------------------------------------------------------------
package itbs_pkg;

  localparam int unsigned TABLE_DEPTH = 16384;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned SLOT_W      = 14;
  localparam int unsigned OFS_W       = 32;
  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned ECNT_W      = 15;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  localparam logic [LEN_W-1:0] FUNC_LIMIT_RST = 32'h0000_2000;
  localparam logic [LEN_W-1:0] PLAIN_LEN_RST  = 32'h0000_0100;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    KIND_EXPLICIT = 2'd0,
    KIND_WHOLE    = 2'd1,
    KIND_TOO_LONG = 2'd2,
    KIND_NONE     = 2'd3
  } copy_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_BASE  = 2'd0,
    CFG_ENTRY_COUNT = 2'd1,
    CFG_FUNC_LIMIT  = 2'd2,
    CFG_PLAIN_LEN   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/itbs_intf.sv =====
// ----------------------------------------------------------------------------
// itbs_intf
// Valid/ready channels of the interval table search block: query/load words,
// result words and configuration writes.
// ----------------------------------------------------------------------------
interface itbs_in_if import itbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [SLOT_W-1:0] entry_index;
  logic [OFS_W-1:0]  begin_offset;
  logic [OFS_W-1:0]  end_offset;
  logic [ADDR_W-1:0] query_address;
  logic [LEN_W-1:0]  requested_length;

  modport source (output valid, action, entry_index, begin_offset, end_offset,
                  query_address, requested_length, input ready);
  modport sink   (input valid, action, entry_index, begin_offset, end_offset,
                  query_address, requested_length, output ready);
endinterface

interface itbs_out_if import itbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              range_found;
  logic [ADDR_W-1:0] range_begin;
  logic [ADDR_W-1:0] range_end;
  logic [ADDR_W-1:0] copy_start;
  logic [LEN_W-1:0]  copy_length;
  logic [1:0]        copy_kind;

  modport source (output valid, range_found, range_begin, range_end, copy_start,
                  copy_length, copy_kind, input ready);
  modport sink   (input valid, range_found, range_begin, range_end, copy_start,
                  copy_length, copy_kind, output ready);
endinterface

interface itbs_cfg_if import itbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/interval_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// interval_table_binary_search
// Function range table with binary search and copy window selection.
// ----------------------------------------------------------------------------
// A load word (action 0) writes one 64-bit entry into the table RAM in the
// cycle it is accepted and yields no result. A query word (action 1) runs a
// binary search over the first entry_count entries: each probe is a
// synchronous RAM read in ST_PROBE followed by a compare in ST_CMP. The input
// is not ready again until the result has been loaded into the output
// register, which waits in ST_DONE while an earlier result is stalled. With
// entry_count saturated to the depth a search makes at most
// ceil(log2(entry_count + 1)) probes, so a full 16384-entry table gives 15
// probes. The result word sits in an output register, so the next word is
// taken while it waits.
// Table entries must be loaded before a search can reach them.
// ----------------------------------------------------------------------------
module interval_table_binary_search import itbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  itbs_in_if.sink    in_i,
  itbs_out_if.source out_o,
  itbs_cfg_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] image_base_q;
  logic [ECNT_W-1:0] entry_count_q;
  logic [LEN_W-1:0]  func_limit_q;
  logic [LEN_W-1:0]  plain_len_q;

  logic [ADDR_W-1:0] addr_q;
  logic [OFS_W-1:0]  offset_q;
  logic [LEN_W-1:0]  req_q;
  logic [CNT_W-1:0]  low_q, high_q;
  logic              found_q;
  logic [OFS_W-1:0]  fb_q, fe_q;

  logic [2*OFS_W-1:0] range_table [TABLE_DEPTH];
  logic [2*OFS_W-1:0] rd_q;

  logic              in_ready, mem_rd, res_load;
  logic              in_acc, mem_wr;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  count_sat;
  logic [OFS_W-1:0]  ent_b, ent_e;
  logic              hit, go_low;
  logic [LEN_W-1:0]  fn_len;
  logic [ADDR_W-1:0] rbeg, rend;

  logic              out_valid_q;
  logic              res_found_q;
  logic [ADDR_W-1:0] res_begin_q, res_end_q, res_start_q;
  logic [LEN_W-1:0]  res_len_q;
  logic [1:0]        res_kind_q;

  assign in_acc   = in_i.valid && in_ready;
  assign mem_wr   = in_acc && (in_i.action == ACT_LOAD) &&
                    (32'(in_i.entry_index) < TABLE_DEPTH);
  assign mid      = low_q + ((high_q - low_q) >> 1);
  assign ent_b    = rd_q[OFS_W-1:0];
  assign ent_e    = rd_q[2*OFS_W-1:OFS_W];
  assign go_low   = offset_q < ent_b;
  assign hit      = !go_low && (offset_q < ent_e);
  assign count_sat = (32'(entry_count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(entry_count_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.action == ACT_QUERY) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        state_d = (low_q < high_q) ? ST_CMP : ST_DONE;
      end
      ST_CMP: begin
        state_d = hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    mem_rd   = 1'b0;
    res_load = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready = 1'b1;
      ST_PROBE: mem_rd   = low_q < high_q;
      ST_CMP:   ;
      ST_DONE:  res_load = !out_valid_q || out_o.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q  <= '0;
      entry_count_q <= '0;
      func_limit_q  <= FUNC_LIMIT_RST;
      plain_len_q   <= PLAIN_LEN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_BASE:  image_base_q  <= cfg_i.data;
        CFG_ENTRY_COUNT: entry_count_q <= cfg_i.data[ECNT_W-1:0];
        CFG_FUNC_LIMIT:  func_limit_q  <= cfg_i.data[LEN_W-1:0];
        CFG_PLAIN_LEN:   plain_len_q   <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // table RAM
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      range_table[IDX_W'(in_i.entry_index)] <= {in_i.end_offset, in_i.begin_offset};
    end
    if (mem_rd) begin
      rd_q <= range_table[mid[IDX_W-1:0]];
    end
  end

  // search datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (in_acc && in_i.action == ACT_QUERY) begin
      found_q <= 1'b0;
    end else if (state_q == ST_CMP && hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.action == ACT_QUERY) begin
      addr_q   <= in_i.query_address;
      offset_q <= OFS_W'(in_i.query_address - image_base_q);
      req_q    <= in_i.requested_length;
      low_q    <= '0;
      high_q   <= count_sat;
      fb_q     <= '0;
      fe_q     <= '0;
    end else if (state_q == ST_CMP) begin
      if (go_low) begin
        high_q <= mid;
      end else if (!hit) begin
        low_q <= mid + CNT_W'(1);
      end else begin
        fb_q <= ent_b;
        fe_q <= ent_e;
      end
    end
  end

  // result
  assign fn_len = fe_q - fb_q;
  assign rbeg   = found_q ? image_base_q + ADDR_W'(fb_q) : '0;
  assign rend   = found_q ? image_base_q + ADDR_W'(fe_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_found_q <= found_q;
      res_begin_q <= rbeg;
      res_end_q   <= rend;
      if (req_q != '0) begin
        res_start_q <= addr_q;
        res_len_q   <= req_q;
        res_kind_q  <= KIND_EXPLICIT;
      end else if (found_q && fn_len <= func_limit_q) begin
        res_start_q <= rbeg;
        res_len_q   <= fn_len;
        res_kind_q  <= KIND_WHOLE;
      end else begin
        res_start_q <= addr_q;
        res_len_q   <= plain_len_q;
        res_kind_q  <= found_q ? KIND_TOO_LONG : KIND_NONE;
      end
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.range_found = res_found_q;
  assign out_o.range_begin = res_begin_q;
  assign out_o.range_end   = res_end_q;
  assign out_o.copy_start  = res_start_q;
  assign out_o.copy_length = res_len_q;
  assign out_o.copy_kind   = res_kind_q;

endmodule

// ===== rtl/itbs_checker.sv =====
// ----------------------------------------------------------------------------
// itbs_checker
// Port-level checks of the interval table search block, bound to the top.
// ----------------------------------------------------------------------------
module itbs_checker import itbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  itbs_in_if.sink    in_i,
  itbs_out_if.source out_o,
  itbs_cfg_if.sink   cfg_i
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.copy_start))
    else $error("result word dropped or changed while stalled");

  // a query occupies the search engine
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.action == ACT_QUERY |=> !in_i.ready)
    else $error("input taken while a search is running");

  // whole-function window is the found range
  a_whole_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.copy_kind == KIND_WHOLE |->
      out_o.range_found && out_o.copy_start == out_o.range_begin &&
      out_o.copy_length == LEN_W'(out_o.range_end - out_o.range_begin))
    else $error("whole-function window does not match range");

  // miss reports zero range and no function-based kind
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.range_found |->
      out_o.range_begin == '0 && out_o.range_end == '0 &&
      out_o.copy_kind != KIND_WHOLE && out_o.copy_kind != KIND_TOO_LONG)
    else $error("miss reported with range data");

  // configuration is never stalled
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |-> cfg_i.ready)
    else $error("configuration write stalled");

endmodule

bind interval_table_binary_search itbs_checker u_itbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o),
  .cfg_i  (cfg_i)
);

// ===== tb/interval_table_binary_search_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_table_binary_search_test
// Self-checking bench for the function range table search block. Loads sorted
// and unsorted range tables, queries boundaries, gaps, empty and oversized
// ranges under several register settings and handshake idling patterns. It
// predicts each result word on input acceptance and checks it in order.
// ----------------------------------------------------------------------------
module interval_table_binary_search_test;
  import itbs_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_PHASES  = 8;

  typedef struct {
    action_e           act;
    logic [SLOT_W-1:0] slot;
    logic [OFS_W-1:0]  lo_ofs;
    logic [OFS_W-1:0]  hi_ofs;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  req_len;
  } in_word_t;

  typedef struct {
    logic              found;
    logic [ADDR_W-1:0] rbegin;
    logic [ADDR_W-1:0] rend;
    logic [ADDR_W-1:0] cstart;
    logic [LEN_W-1:0]  clen;
    copy_kind_e        kind;
  } window_t;

  class window_board;
    bit [2*OFS_W-1:0] ranges [TABLE_DEPTH];
    bit [ADDR_W-1:0]  image_base;
    bit [ECNT_W-1:0]  entry_count;
    bit [LEN_W-1:0]   func_limit = FUNC_LIMIT_RST;
    bit [LEN_W-1:0]   plain_len  = PLAIN_LEN_RST;
    window_t          windows_due[$];
    int unsigned      mismatches;

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_BASE:  image_base  = data;
        CFG_ENTRY_COUNT: entry_count = data[ECNT_W-1:0];
        CFG_FUNC_LIMIT:  func_limit  = data[LEN_W-1:0];
        CFG_PLAIN_LEN:   plain_len   = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned searched();
      return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
    endfunction

    function void note_word(in_word_t w);
      window_t         win;
      bit [ADDR_W-1:0] diff;
      bit [OFS_W-1:0]  ofs, fb, fe, b, e;
      int unsigned     low, high, mid;
      if (w.act == ACT_LOAD) begin
        ranges[w.slot] = {w.hi_ofs, w.lo_ofs};
        return;
      end
      diff = w.addr - image_base;
      ofs = diff[OFS_W-1:0];
      low = 0;
      high = searched();
      win.found = 1'b0;
      fb = '0;
      fe = '0;
      while (low < high) begin
        mid = low + (high - low) / 2;
        b = ranges[mid][OFS_W-1:0];
        e = ranges[mid][2*OFS_W-1:OFS_W];
        if (ofs < b) begin
          high = mid;
        end else if (ofs >= e) begin
          low = mid + 1;
        end else begin
          win.found = 1'b1;
          fb = b;
          fe = e;
          break;
        end
      end
      win.rbegin = win.found ? image_base + fb : '0;
      win.rend   = win.found ? image_base + fe : '0;
      if (w.req_len != 0) begin
        win.cstart = w.addr;
        win.clen   = w.req_len;
        win.kind   = KIND_EXPLICIT;
      end else if (win.found && (fe - fb) <= func_limit) begin
        win.cstart = win.rbegin;
        win.clen   = fe - fb;
        win.kind   = KIND_WHOLE;
      end else begin
        win.cstart = w.addr;
        win.clen   = plain_len;
        win.kind   = win.found ? KIND_TOO_LONG : KIND_NONE;
      end
      windows_due.insert(windows_due.size(), win);
    endfunction

    function void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
      $error("%s: expected %0h, got %0h", field, exp_v, act_v);
      mismatches++;
    endfunction

    function void check_window(window_t got);
      window_t want;
      if (windows_due.size() == 0) begin
        $error("result word with no query pending");
        mismatches++;
        return;
      end
      want = windows_due.pop_front();
      if (got.found !== want.found)   report("range_found", want.found, got.found);
      if (got.rbegin !== want.rbegin) report("range_begin", want.rbegin, got.rbegin);
      if (got.rend !== want.rend)     report("range_end", want.rend, got.rend);
      if (got.cstart !== want.cstart) report("copy_start", want.cstart, got.cstart);
      if (got.clen !== want.clen)     report("copy_length", want.clen, got.clen);
      if (got.kind !== want.kind)     report("copy_kind", want.kind, got.kind);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  itbs_in_if  in_if ();
  itbs_out_if res_if ();
  itbs_cfg_if cfg_if ();

  interval_table_binary_search i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  window_board board;
  int unsigned in_idle_pct   = 0;
  int unsigned out_stall_pct = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done    <= holds_asked;
      hold_left     <= HOLD_CYCLES;
      res_if.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      res_if.ready  <= 1'b0;
    end else begin
      res_if.ready  <= ($urandom_range(99, 0) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    window_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.found  = res_if.range_found;
      got.rbegin = res_if.range_begin;
      got.rend   = res_if.range_end;
      got.cstart = res_if.copy_start;
      got.clen   = res_if.copy_length;
      got.kind   = copy_kind_e'(res_if.copy_kind);
      board.check_window(got);
    end
  end

  function automatic in_word_t load_word(int unsigned slot, bit [31:0] lo, bit [31:0] hi);
    in_word_t w;
    w.act     = ACT_LOAD;
    w.slot    = SLOT_W'(slot);
    w.lo_ofs  = lo;
    w.hi_ofs  = hi;
    w.addr    = {$urandom(), $urandom()};
    w.req_len = $urandom();
    return w;
  endfunction

  function automatic in_word_t query_word(bit [63:0] addr, bit [31:0] req);
    in_word_t w;
    w.act     = ACT_QUERY;
    w.slot    = SLOT_W'($urandom());
    w.lo_ofs  = $urandom();
    w.hi_ofs  = $urandom();
    w.addr    = addr;
    w.req_len = req;
    return w;
  endfunction

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 62; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 62; end
      default: begin in_idle_pct = 37; out_stall_pct = 37; end
    endcase
  endtask

  task automatic send_word(in_word_t w);
    bit go;
    go = 1'b0;
    while (!go) begin
      @(negedge clk);
      go = ($urandom_range(99, 0) >= in_idle_pct);
      if (!go) in_if.valid <= 1'b0;
    end
    in_if.valid            <= 1'b1;
    in_if.action           <= w.act;
    in_if.entry_index      <= w.slot;
    in_if.begin_offset     <= w.lo_ofs;
    in_if.end_offset       <= w.hi_ofs;
    in_if.query_address    <= w.addr;
    in_if.requested_length <= w.req_len;
    do @(posedge clk); while (!in_if.ready);
    board.note_word(w);
  endtask

  // loads leave no result behind, so the drain also covers a search in flight
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (board.windows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_e idx, bit [63:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic configure(bit [63:0] base, int unsigned cnt, bit [31:0] limit,
                           bit [31:0] plain);
    wait_idle();
    cfg_write(CFG_IMAGE_BASE, base);
    cfg_write(CFG_ENTRY_COUNT, 64'(cnt));
    cfg_write(CFG_FUNC_LIMIT, limit);
    cfg_write(CFG_PLAIN_LEN, plain);
  endtask

  // ascending, non-overlapping ranges in slots 0..n-1
  task automatic build_table(int unsigned n, bit [31:0] limit);
    longint unsigned budget, cursor, gap, len;
    budget = 64'h1_0000_0000 / (2 * n + 2);
    cursor = $urandom_range(budget, 0);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(2, 0))
        0: gap = 0;
        1: gap = $urandom_range(16, 1);
        default: gap = $urandom_range(budget / 2, 0);
      endcase
      case ($urandom_range(9, 0))
        0: len = 0;
        1, 2, 3, 4: len = $urandom_range(32'h400, 1);
        5: len = limit;
        6: len = longint'(limit) + 1;
        default: len = $urandom_range(budget, 1);
      endcase
      if (len > budget) len = budget;
      cursor += gap;
      send_word(load_word(i, 32'(cursor), 32'(cursor + len)));
      cursor += len;
    end
  endtask

  // entries only on the leftmost search path of a full-depth count:
  // slot 0 and every power of two, ascending
  task automatic build_path(bit [31:0] limit);
    bit [31:0] lo;
    send_word(load_word(0, 32'h1000, 32'h1100));
    for (int unsigned k = 0; k < IDX_W; k++) begin
      lo = 32'(k + 1) << 20;
      send_word(load_word(1 << k, lo, lo + limit + 32'(k % 2)));
    end
  endtask

  // offsets whose search stays on the path written by build_path
  task automatic run_path_queries(int unsigned items);
    int unsigned pick, slot;
    bit [31:0]   ofs, b, e, req;
    for (int unsigned k = 0; k < items; k++) begin
      case ($urandom_range(3, 0))
        0: ofs = $urandom_range(32'h0FFF, 0);
        1: ofs = $urandom_range(32'hF_FFFF, 32'h1100);
        default: begin
          pick = $urandom_range(IDX_W, 0);
          slot = (pick == IDX_W) ? 0 : (1 << pick);
          b = board.ranges[slot][OFS_W-1:0];
          e = board.ranges[slot][2*OFS_W-1:OFS_W];
          ofs = b + $urandom_range(e - b - 1, 0);
        end
      endcase
      req = ($urandom_range(9, 0) == 0) ? $urandom() : 32'h0;
      send_word(query_word(board.image_base + 64'(ofs), req));
    end
  endtask

  task automatic run_queries(int unsigned items);
    int unsigned span, pick, slot;
    bit [31:0]   ofs, b, e, req;
    bit [63:0]   addr;
    for (int unsigned k = 0; k < items; k++) begin
      if ($urandom_range(99, 0) < 8) begin
        send_word(load_word($urandom_range(TABLE_DEPTH - 1, 0), $urandom(), $urandom()));
      end else begin
        span = board.searched();
        pick = $urandom_range(9, 0);
        ofs = $urandom();
        if (span != 0 && pick < 9) begin
          slot = $urandom_range(span - 1, 0);
          b = board.ranges[slot][OFS_W-1:0];
          e = board.ranges[slot][2*OFS_W-1:OFS_W];
          case (pick)
            0: ofs = b;
            1: ofs = e;
            2: ofs = e - 1;
            default: ofs = (e > b) ? b + $urandom_range(e - b - 1, 0) : b;
          endcase
        end
        if ($urandom_range(9, 0) == 0) addr = {$urandom(), $urandom()};
        else addr = board.image_base + {$urandom(), ofs};
        case ($urandom_range(9, 0))
          7: req = 1;
          8: req = '1;
          9: req = $urandom();
          default: req = 0;
        endcase
        send_word(query_word(addr, req));
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAIL interval_table_binary_search");
    $finish;
  end

  initial begin
    bit [31:0]   probe_ofs [10];
    bit [63:0]   base;
    bit [31:0]   limit, plain;
    int unsigned n;

    board = new;
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.action           = ACT_LOAD;
    in_if.entry_index      = '0;
    in_if.begin_offset     = '0;
    in_if.end_offset       = '0;
    in_if.query_address    = '0;
    in_if.requested_length = '0;
    res_if.ready           = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.index           = CFG_IMAGE_BASE;
    cfg_if.data            = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table straight out of reset
    send_word(query_word(64'h0, 32'h0));
    send_word(query_word('1, '1));

    send_word(load_word(0, 32'h10, 32'h20));
    send_word(load_word(1, 32'h20, 32'h2020));
    send_word(load_word(2, 32'h3000, 32'h5001));
    send_word(load_word(3, 32'h6000, 32'h6000));
    send_word(load_word(4, 32'h8000, 32'hFFFF_FFFF));
    send_word(load_word(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'h0));

    // base just below wrap, so absolute range starts wrap through zero
    configure(64'hFFFF_FFFF_FFFF_FFF0, 5, FUNC_LIMIT_RST, PLAIN_LEN_RST);
    probe_ofs = '{32'h10, 32'h1F, 32'h20, 32'h201F, 32'h3000, 32'h6000,
                  32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5, 32'h5001};
    foreach (probe_ofs[i]) send_word(query_word(board.image_base + probe_ofs[i], 32'h0));
    send_word(query_word(board.image_base + 32'h40, 32'h1));
    send_word(query_word(board.image_base + {32'hA5A5_5A5A, 32'h3000}, 32'h0));

    for (int unsigned p = 0; p < RAND_PHASES; p++) begin
      set_idling(p % 4);
      base  = (p == 1) ? 64'h0 : (p == 2) ? '1 : {$urandom(), $urandom()};
      limit = (p == 3) ? 32'h0 : (p == 4) ? '1 :
              (p == 5) ? FUNC_LIMIT_RST : $urandom_range(32'h2_0000, 0);
      plain = (p == 3) ? 32'h0 : (p == 4) ? '1 : $urandom();
      n     = (p == 0) ? 1 : (p == 6) ? 0 : (p == 7) ? 200 : $urandom_range(80, 2);
      build_table(n, limit);
      configure(base, (p == 5) ? n / 2 : n, limit, plain);
      if (p == 4) holds_asked++;
      run_queries(70);
    end

    // counts at and beyond the depth over a table written along the search path
    set_idling(0);
    limit = $urandom_range(32'h3_0000, 32'h100);
    build_path(limit);
    base = {$urandom(), $urandom()};
    plain = $urandom();
    configure(base, TABLE_DEPTH, limit, plain);
    set_idling(3);
    run_path_queries(30);
    configure(base, 15'h7FFF, limit, plain);
    set_idling(2);
    run_path_queries(30);

    wait_idle();
    if (board.mismatches == 0) begin
      $display("PASS interval_table_binary_search");
    end else begin
      $display("FAIL interval_table_binary_search");
    end
    $finish;
  end

endmodule
